/* rtl/frcs_pkg.sv */
// Shared types and constants for the fiber region crossing selector.
`timescale 1ns / 1ps

package frcs_pkg;

	localparam int MAX_FIBER_VERTICES_DEF   = 65536;
	localparam int SAMPLE_FRACTION_BITS_DEF = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int SAMPLE_W    = 32;
	localparam int FIBER_NUM_W = 24;
	localparam int VERTEX_W    = 16;
	localparam int LENGTH_W    = 17;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_THRESHOLD_A = 2'd0,
		CFG_THRESHOLD_B = 2'd1,
		CFG_CUT_MODE    = 2'd2,
		CFG_SHORTEST    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] threshold_region_a;
		logic signed [SAMPLE_W-1:0] threshold_region_b;
		logic                       cut_mode;
		logic                       shortest_path_mode;
	} cfg_t;

	typedef struct packed {
		logic                matched;
		logic [VERTEX_W-1:0] start_vertex;
		logic [VERTEX_W-1:0] stop_vertex;
		logic [LENGTH_W-1:0] kept_length;
		logic                keep;
	} result_t;

endpackage

/* rtl/fiber_region_crossing_selector.sv */
// Top level of the fiber region crossing selector.
//
// Vertices of fibers arrive on the input channel (in_valid / in_stall), one per
// transaction, with two signed Q16.16 samples, an in-grid flag and a
// last-vertex mark. The vertex with last_vertex set closes the fiber and
// produces exactly one result transaction on the output channel
// (out_valid / out_stall); other vertices produce none.
// out_valid rises after the last vertex is accepted and has passed one input
// register, then a single pass of compare and select logic into the result
// register; a stalled earlier result can hold it in the input register.
// Throughput is one vertex per cycle; the only thing that holds the
// input back is a last vertex waiting while a previous result is still stalled
// in the result register.
// Configuration writes (cfg_valid / cfg_ready, always ready) set the two
// thresholds and the cut and shortest-path modes; write them only while no
// vertex is in flight.
// Reset (arst_n low) clears the fiber state and fiber counter, drops both
// valids, and loads the thresholds with 5.0, cut mode on, longest-path rule.
// While out_stall is high the pending result and its valid hold steady.
`timescale 1ns / 1ps

module fiber_region_crossing_selector #(
	parameter int MAX_FIBER_VERTICES   = frcs_pkg::MAX_FIBER_VERTICES_DEF,
	parameter int SAMPLE_FRACTION_BITS = frcs_pkg::SAMPLE_FRACTION_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [frcs_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [frcs_pkg::CFG_DATA_W-1:0]         cfg_data,

	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [frcs_pkg::SAMPLE_W-1:0]    sample_a,
	input  logic signed [frcs_pkg::SAMPLE_W-1:0]    sample_b,
	input  logic                                    in_grid,
	input  logic                                    last_vertex,

	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [frcs_pkg::FIBER_NUM_W-1:0]        fiber_number,
	output logic                                    matched,
	output logic [frcs_pkg::VERTEX_W-1:0]           start_vertex,
	output logic [frcs_pkg::VERTEX_W-1:0]           stop_vertex,
	output logic [frcs_pkg::LENGTH_W-1:0]           kept_length,
	output logic                                    keep
);

	localparam int IDX_W = $clog2(MAX_FIBER_VERTICES + 1);
	localparam int HIT_W = $clog2(MAX_FIBER_VERTICES);
	localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(MAX_FIBER_VERTICES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FIBER_VERTICES - 1);

	frcs_pkg::cfg_t    cfg;
	frcs_pkg::result_t result;

	// Input register stage.
	logic                                 valid_s1;
	logic signed [frcs_pkg::SAMPLE_W-1:0] sample_a_s1;
	logic signed [frcs_pkg::SAMPLE_W-1:0] sample_b_s1;
	logic                                 in_grid_s1;
	logic                                 last_s1;

	logic                                 in_accept;
	logic                                 proceed;
	logic                                 load_out;

	logic [IDX_W-1:0]                     vidx_q;
	logic [IDX_W-1:0]                     vidx_next;
	logic [HIT_W-1:0]                     hit_idx;
	logic [frcs_pkg::FIBER_NUM_W-1:0]     fiber_cnt_q;

	logic                                 seen_a;
	logic                                 seen_b;
	logic [HIT_W-1:0]                     first_a;
	logic [HIT_W-1:0]                     last_a;
	logic [HIT_W-1:0]                     first_b;
	logic [HIT_W-1:0]                     last_b;

	logic                                 out_valid_q;
	logic [frcs_pkg::FIBER_NUM_W-1:0]     fiber_number_q;
	frcs_pkg::result_t                    result_q;

	frcs_cfg_regs #(
		.SAMPLE_FRACTION_BITS(SAMPLE_FRACTION_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// A vertex that ends a fiber needs room in the result register; others never wait.
	assign proceed   = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !proceed;
	assign in_accept = in_valid && !in_stall;
	assign load_out  = proceed && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (proceed) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_a_s1 <= sample_a;
			sample_b_s1 <= sample_b;
			in_grid_s1  <= in_grid;
			last_s1     <= last_vertex;
		end
	end

	// The vertex index saturates; transitions past the end are pinned to the last index.
	always_comb begin
		vidx_next = (vidx_q < IDX_MAX) ? vidx_q + IDX_W'(1) : vidx_q;
		hit_idx   = (vidx_q > IDX_LAST) ? HIT_W'(IDX_LAST) : HIT_W'(vidx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q      <= '0;
			fiber_cnt_q <= '0;
		end else if (proceed) begin
			if (last_s1) begin
				vidx_q      <= '0;
				fiber_cnt_q <= fiber_cnt_q + frcs_pkg::FIBER_NUM_W'(1);
			end else begin
				vidx_q <= vidx_next;
			end
		end
	end

	frcs_region_track #(
		.HIT_W(HIT_W)
	) u_track_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (proceed),
		.fiber_end(last_s1),
		.in_grid  (in_grid_s1),
		.sample   (sample_a_s1),
		.threshold(cfg.threshold_region_a),
		.idx      (hit_idx),
		.seen_d   (seen_a),
		.first_d  (first_a),
		.last_d   (last_a)
	);

	frcs_region_track #(
		.HIT_W(HIT_W)
	) u_track_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (proceed),
		.fiber_end(last_s1),
		.in_grid  (in_grid_s1),
		.sample   (sample_b_s1),
		.threshold(cfg.threshold_region_b),
		.idx      (hit_idx),
		.seen_d   (seen_b),
		.first_d  (first_b),
		.last_d   (last_b)
	);

	frcs_select #(
		.HIT_W(HIT_W),
		.IDX_W(IDX_W)
	) u_select (
		.cfg         (cfg),
		.seen_a      (seen_a),
		.first_a     (first_a),
		.last_a      (last_a),
		.seen_b      (seen_b),
		.first_b     (first_b),
		.last_b      (last_b),
		.vertex_count(vidx_next),
		.result      (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fiber_number_q <= fiber_cnt_q;
			result_q       <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign fiber_number = fiber_number_q;
	assign matched      = result_q.matched;
	assign start_vertex = result_q.start_vertex;
	assign stop_vertex  = result_q.stop_vertex;
	assign kept_length  = result_q.kept_length;
	assign keep         = result_q.keep;

	// A vertex that does not end a fiber is never held in the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> proceed)
		else $error("non-final vertex was held back");

	// The vertex counter never runs past its saturation value.
	assert property (@(posedge clk) disable iff (!arst_n)
		vidx_q <= IDX_MAX)
		else $error("vertex index beyond saturation");

	// Each finished fiber advances the fiber counter by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (fiber_cnt_q == $past(fiber_cnt_q) + frcs_pkg::FIBER_NUM_W'(1)))
		else $error("fiber counter did not advance by one");

	// An unmatched fiber reports zero indices, zero length and no keep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !matched) |->
			(start_vertex == '0 && stop_vertex == '0 && kept_length == '0 && !keep))
		else $error("unmatched fiber with nonzero selection");

endmodule

/* rtl/frcs_cfg_regs.sv */
// Configuration register file for the fiber region crossing selector.
`timescale 1ns / 1ps

module frcs_cfg_regs #(
	parameter int SAMPLE_FRACTION_BITS = frcs_pkg::SAMPLE_FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [frcs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [frcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output frcs_pkg::cfg_t                      cfg
);

	localparam logic [frcs_pkg::SAMPLE_W-1:0] THR_RESET =
		frcs_pkg::SAMPLE_W'(64'd5 << SAMPLE_FRACTION_BITS);

	frcs_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_region_a <= THR_RESET;
			cfg_q.threshold_region_b <= THR_RESET;
			cfg_q.cut_mode           <= 1'b1;
			cfg_q.shortest_path_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (frcs_pkg::cfg_reg_t'(cfg_index))
				frcs_pkg::CFG_THRESHOLD_A: begin
					cfg_q.threshold_region_a <= cfg_data;
				end
				frcs_pkg::CFG_THRESHOLD_B: begin
					cfg_q.threshold_region_b <= cfg_data;
				end
				frcs_pkg::CFG_CUT_MODE: begin
					cfg_q.cut_mode <= cfg_data[0];
				end
				frcs_pkg::CFG_SHORTEST: begin
					cfg_q.shortest_path_mode <= cfg_data[0];
				end
			endcase
		end
	end

endmodule

/* rtl/frcs_region_track.sv */
// Per-region inside/outside tracker that records first and last transitions.
`timescale 1ns / 1ps

module frcs_region_track #(
	parameter int HIT_W = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic                                 fiber_end,
	input  logic                                 in_grid,
	input  logic signed [frcs_pkg::SAMPLE_W-1:0] sample,
	input  logic signed [frcs_pkg::SAMPLE_W-1:0] threshold,
	input  logic [HIT_W-1:0]                     idx,
	output logic                                 seen_d,
	output logic [HIT_W-1:0]                     first_d,
	output logic [HIT_W-1:0]                     last_d
);

	logic             inside_q;
	logic             seen_q;
	logic [HIT_W-1:0] first_q;
	logic [HIT_W-1:0] last_q;
	logic             now_in;
	logic             trans;
	logic             inside_d;

	always_comb begin
		now_in   = (sample >= threshold);
		trans    = in_grid && (now_in != inside_q);
		inside_d = in_grid ? now_in : inside_q;
		seen_d   = seen_q | trans;
		first_d  = (trans && !seen_q) ? idx : first_q;
		last_d   = trans ? idx : last_q;
	end

	// The whole per-fiber state returns to zero once the last vertex is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			seen_q   <= 1'b0;
			first_q  <= '0;
			last_q   <= '0;
		end else if (step) begin
			if (fiber_end) begin
				inside_q <= 1'b0;
				seen_q   <= 1'b0;
				first_q  <= '0;
				last_q   <= '0;
			end else begin
				inside_q <= inside_d;
				seen_q   <= seen_d;
				first_q  <= first_d;
				last_q   <= last_d;
			end
		end
	end

endmodule

/* rtl/frcs_select.sv */
// Start/stop selection, kept length and keep decision at the end of a fiber.
`timescale 1ns / 1ps

module frcs_select #(
	parameter int HIT_W = 16,
	parameter int IDX_W = 17
) (
	input  frcs_pkg::cfg_t     cfg,
	input  logic               seen_a,
	input  logic [HIT_W-1:0]   first_a,
	input  logic [HIT_W-1:0]   last_a,
	input  logic               seen_b,
	input  logic [HIT_W-1:0]   first_b,
	input  logic [HIT_W-1:0]   last_b,
	input  logic [IDX_W-1:0]   vertex_count,
	output frcs_pkg::result_t  result
);

	logic             matched;
	logic [HIT_W-1:0] s2;
	logic [HIT_W-1:0] e2;
	logic [HIT_W-1:0] start_idx;
	logic [HIT_W-1:0] stop_idx;
	logic [IDX_W-1:0] len_full;

	always_comb begin
		matched   = seen_a && seen_b;
		s2        = cfg.shortest_path_mode ? last_b : first_b;
		e2        = cfg.shortest_path_mode ? first_b : last_b;
		start_idx = (first_a < s2) ? first_a : s2;
		stop_idx  = (last_a > e2) ? last_a : e2;
		// Stop never lies below start, since each region's first hit precedes its last.
		len_full  = cfg.cut_mode ? IDX_W'(stop_idx - start_idx) : vertex_count;

		result.matched      = matched;
		result.start_vertex = matched ? frcs_pkg::VERTEX_W'(start_idx) : '0;
		result.stop_vertex  = matched ? frcs_pkg::VERTEX_W'(stop_idx) : '0;
		result.kept_length  = matched ? frcs_pkg::LENGTH_W'(len_full) : '0;
		result.keep         = matched && (len_full >= IDX_W'(2));
	end

endmodule
